FILE: src/transparent_region_grow_unit_assert.svh
`ifndef TRANSPARENT_REGION_GROW_UNIT_ASSERT_SVH
`define TRANSPARENT_REGION_GROW_UNIT_ASSERT_SVH
// Assertion helpers for the region grow unit.
`define TRG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TRG_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

FILE: src/trg_pkg.sv
`default_nettype none
package trg_pkg;
  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  localparam int unsigned AW = XW + YW;
  localparam logic [7:0] OpaqueLimit = 8'd127;

  localparam logic [1:0] FuncWrite = 2'd0;
  localparam logic [1:0] FuncRun   = 2'd1;
  localparam logic [1:0] FuncRead  = 2'd2;
  localparam logic [1:0] FuncNop   = 2'd3;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegNeigh  = 2'd2;
  localparam logic [1:0] RegRepeat = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } trg_in_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic [7:0]  pass_count;
    logic [12:0] transparent_left;
  } trg_out_t;

  typedef enum logic [3:0] {
    StIdle, StRead, StCopyRd, StCopyWr, StSrcRd, StNbRd, StNbWr,
    StBackRd, StBackWr, StCountRd, StCountAcc, StDone
  } trg_state_e;
endpackage
`default_nettype wire

FILE: src/transparent_region_grow_unit.sv
`default_nettype none
// Transparent region grow unit.
// Channels: a command beat is taken when start_i is high and busy_o low.
// cmd_i.func selects write pixel, run growth, read pixel or no operation.
// Each command yields exactly one result beat on res_o, marked by done_o for
// one cycle; the receiver cannot stall it. The user must write configuration
// through cfg_we_i, cfg_idx_i and cfg_data_i only while the block is idle
// (not enforced by the block); it takes effect for the next command. A write
// passes through StDone to its registered result, a read through StRead and
// StDone. A run walks the frame through one single-port frame memory and one
// work memory, one access per cycle. Each pass copies the frame to the work
// memory, visits all eight neighbors of each opaque pixel in either
// neighborhood mode, stamping transparent ones the mode allows, and copies back;
// a final scan counts transparent pixels. In repeat mode passes go on until
// the transparent count is stable. The block accepts no command while busy_o
// is high, which lasts through done_o. Reset clears the configuration
// registers to their defaults and the pass and transparent counts to zero;
// the pixel memories hold no defined contents until written.
module transparent_region_grow_unit
  import trg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire trg_in_t    cmd_i,
  output logic            done_o,
  output trg_out_t        res_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [6:0] cfg_data_i
);
  logic [31:0] frame_mem [MaxWidth*MaxHeight];
  logic [31:0] work_mem  [MaxWidth*MaxHeight];

  trg_state_e state_q, state_d;
  logic [6:0] width_q, height_q;
  logic neigh_q, repeat_q;
  trg_in_t cmd_q, cmd_d;
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [2:0] nb_q, nb_d;
  logic [31:0] src_q, src_d;
  logic [12:0] cnt_q, cnt_d, prev_q, prev_d;
  logic have_prev_q, have_prev_d;
  logic [7:0] passes_q, passes_d, pass_run_q, pass_run_d;
  logic [12:0] left_q, left_d;
  logic done_q, done_d;
  trg_out_t res_q, res_d;
  logic [31:0] frame_rd_q, work_rd_q;
  logic f_re, f_we, w_re, w_we;
  logic [AW-1:0] f_addr, w_addr;
  logic [31:0] f_wdata, w_wdata;
  logic [XW:0] w_used, nx_w;
  logic [YW:0] h_used, ny_w;
  logic nb_ok;
  logic last_x, last_y;

  always_comb begin
    if (width_q == 7'd0) w_used = (XW+1)'(1);
    else if (width_q > 7'(MaxWidth)) w_used = (XW+1)'(MaxWidth);
    else w_used = (XW+1)'(width_q);
    if (height_q == 7'd0) h_used = (YW+1)'(1);
    else if (height_q > 7'(MaxHeight)) h_used = (YW+1)'(MaxHeight);
    else h_used = (YW+1)'(height_q);
  end

  assign last_x = ({1'b0, x_q} + 1'b1) == w_used;
  assign last_y = ({1'b0, y_q} + 1'b1) == h_used;

  always_comb begin
    nx_w = {1'b0, x_q};
    ny_w = {1'b0, y_q};
    unique case (nb_q)
      3'd0: begin nx_w = {1'b0, x_q} + 1'b1; ny_w = {1'b0, y_q} + 1'b1; end
      3'd1: begin nx_w = {1'b0, x_q} + 1'b1; ny_w = {1'b0, y_q} - 1'b1; end
      3'd2: begin nx_w = {1'b0, x_q} - 1'b1; ny_w = {1'b0, y_q} + 1'b1; end
      3'd3: begin nx_w = {1'b0, x_q} - 1'b1; ny_w = {1'b0, y_q} - 1'b1; end
      3'd4: nx_w = {1'b0, x_q} + 1'b1;
      3'd5: nx_w = {1'b0, x_q} - 1'b1;
      3'd6: ny_w = {1'b0, y_q} + 1'b1;
      3'd7: ny_w = {1'b0, y_q} - 1'b1;
      default: ;
    endcase
    nb_ok = !nx_w[XW] && !ny_w[YW] && (nx_w < w_used) && (ny_w < h_used)
            && (neigh_q || nb_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (f_we) frame_mem[f_addr] <= f_wdata;
    if (f_re) frame_rd_q <= frame_mem[f_addr];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) work_mem[w_addr] <= w_wdata;
    if (w_re) work_rd_q <= work_mem[w_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'(MaxWidth);
      height_q <= 7'(MaxHeight);
      neigh_q  <= 1'b0;
      repeat_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        RegNeigh:  neigh_q  <= cfg_data_i[0];
        RegRepeat: repeat_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      passes_q    <= '0;
      left_q      <= '0;
      done_q      <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      passes_q    <= passes_d;
      left_q      <= left_d;
      done_q      <= done_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    x_q        <= x_d;
    y_q        <= y_d;
    nb_q       <= nb_d;
    src_q      <= src_d;
    cnt_q      <= cnt_d;
    prev_q     <= prev_d;
    pass_run_q <= pass_run_d;
    res_q      <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    x_d         = x_q;
    y_d         = y_q;
    nb_d        = nb_q;
    src_d       = src_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    pass_run_d  = pass_run_q;
    passes_d    = passes_q;
    left_d      = left_q;
    done_d      = 1'b0;
    res_d       = res_q;
    f_re = 1'b0; f_we = 1'b0; w_re = 1'b0; w_we = 1'b0;
    f_addr  = {y_q, x_q};
    w_addr  = {y_q, x_q};
    f_wdata = work_rd_q;
    w_wdata = frame_rd_q;
    unique case (state_q)
      StIdle: begin
        if (start_i && !busy_o) begin
          cmd_d = cmd_i;
          x_d = '0;
          y_d = '0;
          unique case (cmd_i.func)
            FuncWrite: begin
              f_we = 1'b1;
              f_addr = {cmd_i.pos_y[YW-1:0], cmd_i.pos_x[XW-1:0]};
              f_wdata = {cmd_i.in_alpha, cmd_i.in_blue, cmd_i.in_green, cmd_i.in_red};
              state_d = StDone;
            end
            FuncRead: begin
              f_re = 1'b1;
              f_addr = {cmd_i.pos_y[YW-1:0], cmd_i.pos_x[XW-1:0]};
              state_d = StRead;
            end
            FuncRun: begin
              pass_run_d = '0;
              have_prev_d = 1'b0;
              cnt_d = '0;
              state_d = StCopyRd;
            end
            default: state_d = StDone;
          endcase
        end
      end
      StRead: state_d = StDone;
      StCopyRd: begin
        f_re = 1'b1;
        state_d = StCopyWr;
      end
      StCopyWr: begin
        w_we = 1'b1;
        w_wdata = frame_rd_q;
        state_d = StCopyRd;
        if (last_x) begin
          x_d = '0;
          if (last_y) begin
            y_d = '0;
            state_d = StSrcRd;
          end else y_d = y_q + 1'b1;
        end else x_d = x_q + 1'b1;
      end
      StSrcRd: begin
        f_re = 1'b1;
        nb_d = '0;
        state_d = StNbRd;
      end
      StNbRd: begin
        src_d = frame_rd_q;
        state_d = StNbWr;
        w_addr = {ny_w[YW-1:0], nx_w[XW-1:0]};
        w_re = 1'b1;
      end
      StNbWr: begin
        w_addr = {ny_w[YW-1:0], nx_w[XW-1:0]};
        w_wdata = src_q;
        if (src_q[31:24] <= OpaqueLimit) begin
          if (nb_q == 3'd0) cnt_d = cnt_q + 1'b1;
          nb_d = 3'd7;
        end else if (nb_ok && work_rd_q[31:24] <= OpaqueLimit) begin
          w_we = 1'b1;
        end
        if (nb_q == 3'd7 || src_q[31:24] <= OpaqueLimit) begin
          state_d = StSrcRd;
          if (last_y) begin
            y_d = '0;
            if (last_x) begin
              x_d = '0;
              state_d = StBackRd;
            end else x_d = x_q + 1'b1;
          end else y_d = y_q + 1'b1;
        end else begin
          nb_d = nb_q + 1'b1;
          w_addr = {ny_w[YW-1:0], nx_w[XW-1:0]};
          state_d = StNbRd;
        end
      end
      StBackRd: begin
        w_re = 1'b1;
        state_d = StBackWr;
      end
      StBackWr: begin
        f_we = 1'b1;
        f_wdata = work_rd_q;
        state_d = StBackRd;
        if (last_x) begin
          x_d = '0;
          if (last_y) begin
            y_d = '0;
            if (pass_run_q != 8'd255) pass_run_d = pass_run_q + 1'b1;
            cnt_d = '0;
            prev_d = cnt_q;
            have_prev_d = 1'b1;
            if (!repeat_q || (have_prev_q && cnt_q == prev_q)) begin
              left_d = '0;
              state_d = StCountRd;
            end else state_d = StCopyRd;
          end else y_d = y_q + 1'b1;
        end else x_d = x_q + 1'b1;
      end
      StCountRd: begin
        f_re = 1'b1;
        state_d = StCountAcc;
      end
      StCountAcc: begin
        if (frame_rd_q[31:24] <= OpaqueLimit) left_d = left_q + 1'b1;
        state_d = StCountRd;
        if (last_x) begin
          x_d = '0;
          if (last_y) begin
            passes_d = pass_run_q;
            state_d = StDone;
          end else y_d = y_q + 1'b1;
        end else x_d = x_q + 1'b1;
      end
      StDone: begin
        done_d = 1'b1;
        res_d.pass_count = passes_q;
        res_d.transparent_left = left_q;
        if (cmd_q.func == FuncRead) begin
          res_d.out_red   = frame_rd_q[7:0];
          res_d.out_green = frame_rd_q[15:8];
          res_d.out_blue  = frame_rd_q[23:16];
          res_d.out_alpha = frame_rd_q[31:24];
        end else begin
          res_d.out_red = '0; res_d.out_green = '0;
          res_d.out_blue = '0; res_d.out_alpha = '0;
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle) || done_q;
  assign done_o = done_q;
  assign res_o  = res_q;
endmodule
`default_nettype wire

FILE: src/trg_checker.sv
`default_nettype none
`include "transparent_region_grow_unit_assert.svh"
module trg_checker
  import trg_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start_i,
  input wire logic     busy_o,
  input wire logic     done_o,
  input wire trg_out_t res_o
);
  `TRG_ASSERT_RST(a_rst_quiet, !rst_ni |-> !done_o, "done during reset")
  `TRG_ASSERT(a_done_pulse, done_o |=> !done_o, "done longer than one cycle")
  `TRG_ASSERT(a_done_busy, done_o |-> busy_o, "done while idle")
  `TRG_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "no busy after accept")
  `TRG_ASSERT(a_res_known, done_o |-> !$isunknown(res_o), "unknown result beat")
endmodule

bind transparent_region_grow_unit trg_checker u_trg_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .done_o(done_o), .res_o(res_o)
);
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import trg_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  trg_in_t    cmd_i = '0;
  logic       done_o;
  trg_out_t   res_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = RegWidth;
  logic [6:0] cfg_data_i = '0;

  transparent_region_grow_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .cmd_i(cmd_i), .done_o(done_o), .res_o(res_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  trg_in_t  cmd_q[$];
  trg_out_t pixel_results_q[$];
  int       idle_pct = 14;
  int       fail_cnt = 0;
  int       beats_sent = 0;
  int       beats_checked = 0;
  int       runs_sent = 0;

  // Predicted block state.
  logic [31:0] frame_px[4096];
  logic [31:0] work_px[4096];
  logic [7:0]  passes_q;
  logic [12:0] left_q;
  logic [6:0]  reg_w = 7'd64;
  logic [6:0]  reg_h = 7'd64;
  logic        reg_diag = 1'b0;
  logic        reg_rep = 1'b1;

  // Pixels written so far by the generated command stream.
  bit gen_written[4096];

  function automatic int eff_size(logic [6:0] v);
    if (v == 0) return 1;
    return (v > 64) ? 64 : int'(v);
  endfunction

  function automatic bit opaque(logic [31:0] px);
    return px[31:24] > OpaqueLimit;
  endfunction

  function automatic void stamp_px(int x, int y, logic [31:0] px);
    if (!opaque(work_px[y * 64 + x])) work_px[y * 64 + x] = px;
  endfunction

  function automatic int grow_once(int w, int h);
    int cnt;
    logic [31:0] px;
    cnt = 0;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) work_px[y * 64 + x] = frame_px[y * 64 + x];
    for (int x = 0; x < w; x++) begin
      for (int y = 0; y < h; y++) begin
        px = frame_px[y * 64 + x];
        if (!opaque(px)) begin
          cnt++;
        end else begin
          if (reg_diag) begin
            if (y + 1 < h && x + 1 < w) stamp_px(x + 1, y + 1, px);
            if (y > 0 && x + 1 < w) stamp_px(x + 1, y - 1, px);
            if (y + 1 < h && x > 0) stamp_px(x - 1, y + 1, px);
            if (y > 0 && x > 0) stamp_px(x - 1, y - 1, px);
          end
          if (x + 1 < w) stamp_px(x + 1, y, px);
          if (x > 0) stamp_px(x - 1, y, px);
          if (y + 1 < h) stamp_px(x, y + 1, px);
          if (y > 0) stamp_px(x, y - 1, px);
        end
      end
    end
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) frame_px[y * 64 + x] = work_px[y * 64 + x];
    return cnt;
  endfunction

  function automatic void grow_region();
    int w, h, passes, prev, cnt, left;
    bit have_prev;
    w = eff_size(reg_w);
    h = eff_size(reg_h);
    passes = 0;
    prev = 0;
    left = 0;
    have_prev = 0;
    for (int g = 0; g < 4098; g++) begin
      cnt = grow_once(w, h);
      if (passes < 255) passes++;
      if (!reg_rep) break;
      if (have_prev && cnt == prev) break;
      prev = cnt;
      have_prev = 1;
    end
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        if (!opaque(frame_px[y * 64 + x])) left++;
    passes_q = passes[7:0];
    left_q = left[12:0];
  endfunction

  function automatic trg_out_t predict_result(trg_in_t c);
    trg_out_t r;
    logic [31:0] px;
    px = '0;
    case (c.func)
      FuncWrite: frame_px[{c.pos_y, c.pos_x}] =
          {c.in_alpha, c.in_blue, c.in_green, c.in_red};
      FuncRun: grow_region();
      FuncRead: px = frame_px[{c.pos_y, c.pos_x}];
      default: ;
    endcase
    r.out_red = px[7:0];
    r.out_green = px[15:8];
    r.out_blue = px[23:16];
    r.out_alpha = px[31:24];
    r.pass_count = passes_q;
    r.transparent_left = left_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    fail_cnt++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        pixel_results_q.push_back(predict_result(cmd_i));
        beats_sent++;
      end
      if (!(start_i && busy_o)) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start_i <= 1'b1;
          cmd_i <= cmd_q.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    trg_out_t want;
    if (rst_ni && done_o) begin
      if (pixel_results_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = pixel_results_q.pop_front();
        beats_checked++;
        if (res_o.out_red !== want.out_red)
          report_mismatch("out_red", res_o.out_red, want.out_red);
        if (res_o.out_green !== want.out_green)
          report_mismatch("out_green", res_o.out_green, want.out_green);
        if (res_o.out_blue !== want.out_blue)
          report_mismatch("out_blue", res_o.out_blue, want.out_blue);
        if (res_o.out_alpha !== want.out_alpha)
          report_mismatch("out_alpha", res_o.out_alpha, want.out_alpha);
        if (res_o.pass_count !== want.pass_count)
          report_mismatch("pass_count", res_o.pass_count, want.pass_count);
        if (res_o.transparent_left !== want.transparent_left)
          report_mismatch("transparent_left", res_o.transparent_left,
                          want.transparent_left);
      end
    end
  end

  task automatic push_write(int x, int y, logic [31:0] px);
    trg_in_t c;
    c.func = FuncWrite;
    c.pos_x = x[5:0];
    c.pos_y = y[5:0];
    {c.in_alpha, c.in_blue, c.in_green, c.in_red} = px;
    cmd_q.push_back(c);
    gen_written[y * 64 + x] = 1;
  endtask

  task automatic push_cmd(logic [1:0] f, int x, int y);
    trg_in_t c;
    c = '0;
    {c.in_alpha, c.in_blue, c.in_green, c.in_red} = $urandom();
    c.func = f;
    c.pos_x = x[5:0];
    c.pos_y = y[5:0];
    cmd_q.push_back(c);
    if (f == FuncRun) runs_sent++;
  endtask

  task automatic push_read_written();
    int x, y;
    for (int k = 0; k < 50; k++) begin
      x = $urandom_range(63);
      y = $urandom_range(63);
      if (k > 25) begin
        x = $urandom_range(eff_size(reg_w) - 1);
        y = $urandom_range(eff_size(reg_h) - 1);
      end
      if (gen_written[y * 64 + x]) begin
        push_cmd(FuncRead, x, y);
        return;
      end
    end
  endtask

  task automatic push_run();
    for (int y = 0; y < eff_size(reg_h); y++)
      for (int x = 0; x < eff_size(reg_w); x++)
        if (!gen_written[y * 64 + x]) push_write(x, y, $urandom());
    push_cmd(FuncRun, 0, 0);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (cmd_q.size() != 0 || start_i || pixel_results_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [6:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegWidth: reg_w = val;
      RegHeight: reg_h = val;
      RegNeigh: reg_diag = val[0];
      default: reg_rep = val[0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(logic [6:0] w, logic [6:0] h, bit diag, bit rep);
    drain();
    set_reg(RegWidth, w);
    set_reg(RegHeight, h);
    set_reg(RegNeigh, {6'd0, diag});
    set_reg(RegRepeat, {6'd0, rep});
  endtask

  task automatic random_batch(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        push_write($urandom_range(eff_size(reg_w) - 1),
                   $urandom_range(eff_size(reg_h) - 1), $urandom());
      end else if (sel < 55) begin
        push_write($urandom_range(63), $urandom_range(63), $urandom());
      end else if (sel < 88) begin
        push_read_written();
      end else if (sel < 94) begin
        push_run();
      end else begin
        push_cmd(FuncNop, $urandom_range(63), $urandom_range(63));
      end
    end
  endtask

  initial begin
    passes_q = '0;
    left_q = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_all(7'd3, 7'd2, 1'b0, 1'b0);
    push_write(0, 0, 32'h0000_0000);
    push_write(63, 63, 32'hFFFF_FFFF);
    push_write(1, 0, 32'h7F11_2233);
    push_write(2, 0, 32'h80AA_BBCC);
    push_write(0, 1, 32'h7FFF_FFFF);
    push_write(1, 1, 32'h8000_0000);
    push_write(2, 1, 32'h0102_0304);
    push_write(40, 63, 32'h1234_5678);
    push_cmd(FuncRead, 63, 63);
    push_cmd(FuncRead, 0, 0);
    push_cmd(FuncRead, 40, 63);
    push_cmd(FuncNop, 63, 63);
    push_run();
    push_cmd(FuncRead, 0, 0);
    push_cmd(FuncRead, 1, 0);
    push_cmd(FuncRead, 63, 63);
    set_all(7'd3, 7'd2, 1'b1, 1'b1);
    push_run();
    push_cmd(FuncRead, 0, 1);
    push_cmd(FuncRead, 2, 1);

    set_all(7'd0, 7'd127, 1'b0, 1'b1);
    push_run();
    set_all(7'd127, 7'd0, 1'b1, 1'b1);
    push_run();

    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 8) begin
        drain();
        idle_pct = 88;
      end else if (ph == 16) begin
        drain();
        idle_pct = 0;
      end
      set_all(7'($urandom_range(1, 6)), 7'($urandom_range(1, 6)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
      random_batch(55);
    end

    set_all(7'd64, 7'd4, 1'b1, 1'b0);
    push_run();
    for (int i = 0; i < 20; i++) push_read_written();
    drain();

    $display("Checked %0d result beats from %0d command beats, %0d of them grow runs,",
             beats_checked, beats_sent, runs_sent);
    $display("over region sizes from 1x1 up to the full 64-pixel width and height.");
    if (fail_cnt == 0) begin
      $display("transparent_region_grow_unit test passed");
    end else begin
      $display("transparent_region_grow_unit test failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("transparent_region_grow_unit test failed");
    $finish;
  end
endmodule
`default_nettype wire
